// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/bpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpq_pkg;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        func;
    logic [7:0]  priority_req;
    logic [15:0] order_key;
    logic [15:0] payload;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_payload;
    logic [15:0] out_key;
    logic [7:0]  out_priority;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLOAD,
    ST_PCMP,
    ST_PLINK,
    ST_PFIX,
    ST_SCHK,
    ST_NGET,
    ST_TCHK,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/bpq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpq_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bpq_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpq_seq #(
  parameter int POOL_SIZE    = 1024,
  parameter int TOP_PRIORITY = 255,
  localparam int LinkW   = $clog2(POOL_SIZE + 1),
  localparam int AddrW   = $clog2(POOL_SIZE),
  localparam int BucketW = $clog2(TOP_PRIORITY + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire bpq_pkg::item_t       item_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output bpq_pkg::result_t          res_o,
  output logic                      bh_we_o,
  output logic      [BucketW-1:0]   bh_waddr_o,
  output logic      [LinkW-1:0]     bh_wdata_o,
  output logic      [BucketW-1:0]   bh_raddr_o,
  input  wire logic [LinkW-1:0]     bh_rdata_i,
  output logic                      nx_we_o,
  output logic      [AddrW-1:0]     nx_waddr_o,
  output logic      [LinkW-1:0]     nx_wdata_o,
  output logic      [AddrW-1:0]     nx_raddr_o,
  input  wire logic [LinkW-1:0]     nx_rdata_i,
  output logic                      dt_we_o,
  output logic      [AddrW-1:0]     dt_waddr_o,
  output logic      [31:0]          dt_wdata_o,
  output logic      [AddrW-1:0]     dt_raddr_o,
  input  wire logic [31:0]          dt_rdata_i
);

  localparam int PrioW = (BucketW > 8) ? BucketW : 8;
  localparam logic [LinkW-1:0]   NullLink = LinkW'(POOL_SIZE);
  localparam logic [BucketW-1:0] TopIdx   = BucketW'(TOP_PRIORITY);
  localparam logic [PrioW-1:0]   TopWide  = PrioW'(TOP_PRIORITY);
  localparam logic [LinkW-1:0]   OneLink  = LinkW'(1);

  bpq_pkg::state_e state_q, state_d;

  logic [BucketW-1:0] clr_q, clr_d;
  logic [BucketW-1:0] prio_q, prio_d;
  logic [15:0]        key_q, key_d;
  logic [15:0]        pay_q, pay_d;
  logic [LinkW-1:0]   cur_q, cur_d;
  logic [LinkW-1:0]   prev_q, prev_d;
  logic               at_head_q, at_head_d;
  logic [BucketW-1:0] b_q, b_d;
  logic [LinkW-1:0]   alloc_q, alloc_d;
  logic [LinkW-1:0]   count_q, count_d;
  logic [BucketW-1:0] top_q, top_d;
  bpq_pkg::result_t   res_q, res_d;

  logic [PrioW-1:0]   prio_wide;
  logic [BucketW-1:0] prio_sat;
  logic [15:0]        node_key;
  logic [15:0]        node_pay;
  logic               key_after;
  logic [BucketW-1:0] b_dec;

  assign prio_wide = PrioW'(item_i.priority_req);
  assign prio_sat  = (prio_wide > TopWide) ? TopIdx : BucketW'(prio_wide);
  assign node_key  = dt_rdata_i[31:16];
  assign node_pay  = dt_rdata_i[15:0];
  // shared compare: new entry passes over nodes with strictly smaller keys
  assign key_after = key_q > node_key;
  assign b_dec     = b_q - 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpq_pkg::ST_CLEAR: begin
        if (clr_q == TopIdx) state_d = bpq_pkg::ST_IDLE;
      end
      bpq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (item_i.func == bpq_pkg::FUNC_PUSH) begin
            state_d = (alloc_q == NullLink) ? bpq_pkg::ST_DONE : bpq_pkg::ST_PLOAD;
          end else begin
            state_d = (count_q == '0) ? bpq_pkg::ST_DONE : bpq_pkg::ST_SCHK;
          end
        end
      end
      bpq_pkg::ST_PLOAD: begin
        state_d = (bh_rdata_i == NullLink) ? bpq_pkg::ST_PLINK : bpq_pkg::ST_PCMP;
      end
      bpq_pkg::ST_PCMP: begin
        if (!key_after || nx_rdata_i == NullLink) state_d = bpq_pkg::ST_PLINK;
      end
      bpq_pkg::ST_PLINK: begin
        state_d = at_head_q ? bpq_pkg::ST_DONE : bpq_pkg::ST_PFIX;
      end
      bpq_pkg::ST_PFIX: begin
        state_d = bpq_pkg::ST_DONE;
      end
      bpq_pkg::ST_SCHK: begin
        if (bh_rdata_i != NullLink) state_d = bpq_pkg::ST_NGET;
        else if (b_q == '0)         state_d = bpq_pkg::ST_DONE;
      end
      bpq_pkg::ST_NGET: begin
        if (nx_rdata_i != NullLink || b_q == '0 || count_q == OneLink) begin
          state_d = bpq_pkg::ST_DONE;
        end else begin
          state_d = bpq_pkg::ST_TCHK;
        end
      end
      bpq_pkg::ST_TCHK: begin
        if (bh_rdata_i != NullLink || b_q == '0) state_d = bpq_pkg::ST_DONE;
      end
      bpq_pkg::ST_DONE: begin
        if (res_ready_i) state_d = bpq_pkg::ST_IDLE;
      end
      default: state_d = bpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    clr_d     = clr_q;
    prio_d    = prio_q;
    key_d     = key_q;
    pay_d     = pay_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    at_head_d = at_head_q;
    b_d       = b_q;
    alloc_d   = alloc_q;
    count_d   = count_q;
    top_d     = top_q;
    res_d     = res_q;

    bh_we_o    = 1'b0;
    bh_waddr_o = b_q;
    bh_wdata_o = nx_rdata_i;
    bh_raddr_o = b_dec;
    nx_we_o    = 1'b0;
    nx_waddr_o = alloc_q[AddrW-1:0];
    nx_wdata_o = cur_q;
    nx_raddr_o = nx_rdata_i[AddrW-1:0];
    dt_we_o    = 1'b0;
    dt_waddr_o = alloc_q[AddrW-1:0];
    dt_wdata_o = {key_q, pay_q};
    dt_raddr_o = nx_rdata_i[AddrW-1:0];

    unique case (state_q)
      bpq_pkg::ST_CLEAR: begin
        bh_we_o    = 1'b1;
        bh_waddr_o = clr_q;
        bh_wdata_o = NullLink;
        clr_d      = clr_q + 1'b1;
      end
      bpq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          prio_d    = prio_sat;
          key_d     = item_i.order_key;
          pay_d     = item_i.payload;
          prev_d    = NullLink;
          at_head_d = 1'b1;
          res_d     = '0;
          if (item_i.func == bpq_pkg::FUNC_PUSH) begin
            bh_raddr_o = prio_sat;
            if (alloc_q == NullLink) res_d.status = bpq_pkg::STATUS_FULL;
          end else begin
            bh_raddr_o = top_q;
            b_d        = top_q;
            if (count_q == '0) begin
              res_d.status = bpq_pkg::STATUS_EMPTY;
              top_d        = '0;
            end
          end
        end
      end
      bpq_pkg::ST_PLOAD: begin
        cur_d      = bh_rdata_i;
        nx_raddr_o = bh_rdata_i[AddrW-1:0];
        dt_raddr_o = bh_rdata_i[AddrW-1:0];
      end
      bpq_pkg::ST_PCMP: begin
        if (key_after) begin
          prev_d    = cur_q;
          at_head_d = 1'b0;
          cur_d     = nx_rdata_i;
        end
      end
      bpq_pkg::ST_PLINK: begin
        dt_we_o = 1'b1;
        nx_we_o = 1'b1;
        if (at_head_q) begin
          bh_we_o    = 1'b1;
          bh_waddr_o = prio_q;
          bh_wdata_o = alloc_q;
        end
        alloc_d = alloc_q + 1'b1;
        count_d = count_q + 1'b1;
        if (prio_q > top_q) top_d = prio_q;
      end
      bpq_pkg::ST_PFIX: begin
        // alloc already advanced; the new slot is one below it
        nx_we_o    = 1'b1;
        nx_waddr_o = prev_q[AddrW-1:0];
        nx_wdata_o = alloc_q - 1'b1;
      end
      bpq_pkg::ST_SCHK: begin
        nx_raddr_o = bh_rdata_i[AddrW-1:0];
        dt_raddr_o = bh_rdata_i[AddrW-1:0];
        if (bh_rdata_i == NullLink) begin
          if (b_q == '0) begin
            res_d.status = bpq_pkg::STATUS_EMPTY;
            top_d        = '0;
          end else begin
            b_d = b_dec;
          end
        end
      end
      bpq_pkg::ST_NGET: begin
        res_d.status       = bpq_pkg::STATUS_OK;
        res_d.out_payload  = node_pay;
        res_d.out_key      = node_key;
        res_d.out_priority = 8'(b_q);
        bh_we_o            = 1'b1;
        count_d            = count_q - 1'b1;
        if (nx_rdata_i != NullLink) begin
          top_d = b_q;
        end else if (b_q == '0 || count_q == OneLink) begin
          top_d = '0;
        end else begin
          b_d = b_dec;
        end
      end
      bpq_pkg::ST_TCHK: begin
        if (bh_rdata_i != NullLink || b_q == '0) top_d = b_q;
        else                                     b_d   = b_dec;
      end
      bpq_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpq_pkg::ST_CLEAR;
      clr_q   <= '0;
      alloc_q <= '0;
      count_q <= '0;
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      alloc_q <= alloc_d;
      count_q <= count_d;
      top_q   <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q    <= prio_d;
    key_q     <= key_d;
    pay_q     <= pay_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    at_head_q <= at_head_d;
    b_q       <= b_d;
    res_q     <= res_d;
  end

  assign in_ready_o  = (state_q == bpq_pkg::ST_IDLE);
  assign res_valid_o = (state_q == bpq_pkg::ST_DONE);
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bucket_priority_queue_core.sv =====
// Bucketed priority queue with 256 buckets over a pool of 1024 nodes (by default).
// Input channel (in_valid_i/in_ready_o) takes one item: func_i 0 pushes
// {priority_req_i, order_key_i, payload_i}, func_i 1 pops the head of the highest
// non-empty bucket. Output channel (out_valid_o/out_ready_i) returns one item per
// input item: status_o plus the popped payload, key and bucket (zero otherwise).
// One item is worked at a time; in_ready_o is low while the sequencer runs.
// Push reads the bucket head, compares the key against each list node in turn, then
// links the entry, with one more step to fix the predecessor's link when the entry
// does not land at the head of its bucket; a full pool answers without a walk.
// Pop scans down from the top bucket past empty buckets to the best one and takes its
// head; when that bucket empties and entries remain, it checks the buckets below it
// down to the next non-empty one. An empty queue answers without a scan.
// The walk is set by the single read port on the head and node memories.
// After reset the bucket head memory is swept to null, one bucket per cycle,
// through all TOP_PRIORITY + 1 buckets, before in_ready_o rises. Node slots are never reused.
// The result sits in an output register; while the receiver stalls it holds, and
// the block may take the next item and finish it up to the point of delivery.
`timescale 1ns / 1ps
`default_nettype none

module bucket_priority_queue_core #(
  parameter int POOL_SIZE    = 1024,
  parameter int TOP_PRIORITY = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [7:0]  priority_req_i,
  input  wire logic [15:0] order_key_i,
  input  wire logic [15:0] payload_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [1:0]  status_o,
  output logic      [15:0] out_payload_o,
  output logic      [15:0] out_key_o,
  output logic      [7:0]  out_priority_o
);

  localparam int LinkW      = $clog2(POOL_SIZE + 1);
  localparam int AddrW      = $clog2(POOL_SIZE);
  localparam int NumBuckets = TOP_PRIORITY + 1;
  localparam int BucketW    = $clog2(NumBuckets);

  bpq_pkg::item_t   item;
  bpq_pkg::result_t res;
  bpq_pkg::result_t out_q;
  logic             out_valid_q;
  logic             res_valid;
  logic             res_ready;

  logic               bh_we;
  logic [BucketW-1:0] bh_waddr, bh_raddr;
  logic [LinkW-1:0]   bh_wdata, bh_rdata;
  logic               nx_we;
  logic [AddrW-1:0]   nx_waddr, nx_raddr;
  logic [LinkW-1:0]   nx_wdata, nx_rdata;
  logic               dt_we;
  logic [AddrW-1:0]   dt_waddr, dt_raddr;
  logic [31:0]        dt_wdata, dt_rdata;

  assign item.func         = func_i;
  assign item.priority_req = priority_req_i;
  assign item.order_key    = order_key_i;
  assign item.payload      = payload_i;

  bpq_seq #(
    .POOL_SIZE   (POOL_SIZE),
    .TOP_PRIORITY(TOP_PRIORITY)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .bh_we_o    (bh_we),
    .bh_waddr_o (bh_waddr),
    .bh_wdata_o (bh_wdata),
    .bh_raddr_o (bh_raddr),
    .bh_rdata_i (bh_rdata),
    .nx_we_o    (nx_we),
    .nx_waddr_o (nx_waddr),
    .nx_wdata_o (nx_wdata),
    .nx_raddr_o (nx_raddr),
    .nx_rdata_i (nx_rdata),
    .dt_we_o    (dt_we),
    .dt_waddr_o (dt_waddr),
    .dt_wdata_o (dt_wdata),
    .dt_raddr_o (dt_raddr),
    .dt_rdata_i (dt_rdata)
  );

  bpq_ram #(.Width(LinkW), .Depth(NumBuckets)) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (bh_we),
    .waddr_i(bh_waddr),
    .wdata_i(bh_wdata),
    .raddr_i(bh_raddr),
    .rdata_o(bh_rdata)
  );

  bpq_ram #(.Width(LinkW), .Depth(POOL_SIZE)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (nx_we),
    .waddr_i(nx_waddr),
    .wdata_i(nx_wdata),
    .raddr_i(nx_raddr),
    .rdata_o(nx_rdata)
  );

  // key in the upper half, payload in the lower half
  bpq_ram #(.Width(32), .Depth(POOL_SIZE)) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (dt_we),
    .waddr_i(dt_waddr),
    .wdata_i(dt_wdata),
    .raddr_i(dt_raddr),
    .rdata_o(dt_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign out_payload_o  = out_q.out_payload;
  assign out_key_o      = out_q.out_key;
  assign out_priority_o = out_q.out_priority;

endmodule

`default_nettype wire

// ===== hw/rtl/bpq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bpq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_i,
  input wire logic [15:0] out_payload_i,
  input wire logic [15:0] out_key_i,
  input wire logic [7:0]  out_priority_i
);

  logic        err_result;
  logic        status_known;
  logic        entry_zero;
  logic        out_stall;
  logic [41:0] out_bus;

  assign err_result   = out_valid_i && (status_i != bpq_pkg::STATUS_OK);
  assign status_known = (status_i == bpq_pkg::STATUS_OK) ||
                        (status_i == bpq_pkg::STATUS_FULL) ||
                        (status_i == bpq_pkg::STATUS_EMPTY);
  assign entry_zero   = (out_payload_i == '0) && (out_key_i == '0) &&
                        (out_priority_i == '0);
  assign out_stall    = out_valid_i && !out_ready_i;
  assign out_bus      = {status_i, out_payload_i, out_key_i, out_priority_i};

  // only one item in flight: accepting drops ready
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  `ASSERT_IMPLIES(a_status_code, clk_i, rst_ni, out_valid_i, status_known)

  // error answers carry no entry
  `ASSERT_IMPLIES(a_err_zero, clk_i, rst_ni, err_result, entry_zero)

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_bus))

endmodule

bind bucket_priority_queue_core bpq_checker u_bpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_i    (in_ready_o),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_i      (status_o),
  .out_payload_i (out_payload_o),
  .out_key_i     (out_key_o),
  .out_priority_i(out_priority_o)
);

`default_nettype wire
